/* src/gha_pkg.sv */
// shared types and port widths of the generational handle allocator
package gha_pkg;

	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 8;
	localparam int PGEN_W   = 32;
	localparam int STATUS_W = 2;
	localparam int RIDX_W   = 9;
	localparam int PCNT_W   = 9;

	typedef enum logic [MODE_W-1:0] {
		OP_CREATE   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_VALIDATE = 2'd2,
		OP_SCAN     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_STALE = 2'd2,
		ST_END   = 2'd3
	} status_t;

	// one classified command beat between front and back
	typedef struct packed {
		op_t               op;
		logic              inv_gen;
		logic [SLOT_W-1:0] idx;
		logic [PGEN_W-1:0] gen;
	} cmd_t;

	// one result beat
	typedef struct packed {
		status_t           status;
		logic [RIDX_W-1:0] index;
		logic [PGEN_W-1:0] gen;
		logic [PCNT_W-1:0] live;
		logic [PCNT_W-1:0] used;
	} res_t;

endpackage

/* src/gha_ram.sv */
// generic single-write, single-read ram with registered read data
module gha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/gha_front.sv */
// front end: takes command beats, decodes them and queues them for the back end
module gha_front #(
	parameter int GEN_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [gha_pkg::MODE_W-1:0]  mode,
	input  logic [gha_pkg::SLOT_W-1:0]  slot_index,
	input  logic [gha_pkg::PGEN_W-1:0]  generation,
	output logic                        q_valid,
	output gha_pkg::cmd_t               q_item,
	input  logic                        q_pop
);

	localparam int Q_DEPTH = 2;

	gha_pkg::cmd_t fifo_q [Q_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	gha_pkg::cmd_t cmd_in;
	logic [GEN_WIDTH-1:0] gen_trim;

	assign busy = (cnt_q == 2'(Q_DEPTH));
	assign push = start && !busy;
	assign gen_trim = GEN_WIDTH'(generation);

	always_comb begin
		cmd_in.idx = slot_index;
		cmd_in.gen = generation;
		// top bit of the generation word marks a handle that can never be live
		cmd_in.inv_gen = gen_trim[GEN_WIDTH-1];
		unique case (mode)
			gha_pkg::OP_CREATE:   cmd_in.op = gha_pkg::OP_CREATE;
			gha_pkg::OP_DELETE:   cmd_in.op = gha_pkg::OP_DELETE;
			gha_pkg::OP_VALIDATE: cmd_in.op = gha_pkg::OP_VALIDATE;
			default:              cmd_in.op = gha_pkg::OP_SCAN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

endmodule

/* src/gha_back.sv */
// back end: slot state, generation table and free stack, executes one command at a time
module gha_back #(
	parameter int SLOT_COUNT = 256,
	parameter int GEN_WIDTH  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  gha_pkg::cmd_t q_item,
	output logic          q_pop,
	output logic          done,
	output gha_pkg::res_t res
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W = (CNT_W > gha_pkg::SLOT_W) ? CNT_W : gha_pkg::SLOT_W;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_STK      = 6'b000010,
		S_REUSE    = 6'b000100,
		S_CHK      = 6'b001000,
		S_SCAN     = 6'b010000,
		S_SCAN_CHK = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     fd_q, fd_d;
	logic [CNT_W-1:0]     hw_q, hw_d;
	logic [CMP_W-1:0]     scan_q, scan_d;
	gha_pkg::op_t         op_q;
	logic [gha_pkg::SLOT_W-1:0] idx_q;
	logic [GEN_WIDTH-1:0] gen_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 done_q;
	gha_pkg::res_t        res_q;

	logic                 emit;
	gha_pkg::status_t     e_status;
	logic [gha_pkg::RIDX_W-1:0] e_index;
	logic [gha_pkg::PGEN_W-1:0] e_gen;
	logic                 load_slot;

	logic                 tbl_we, tbl_re;
	logic [IDX_W-1:0]     tbl_waddr, tbl_raddr;
	logic [GEN_WIDTH-1:0] tbl_wdata, tbl_rdata;
	logic                 stk_we, stk_re;
	logic [IDX_W-1:0]     stk_waddr, stk_raddr;
	logic [IDX_W-1:0]     stk_wdata, stk_rdata;

	logic                 pre_ok;
	logic                 match;
	logic [GEN_WIDTH-1:0] bumped;

	assign pre_ok = (CMP_W'(q_item.idx) < CMP_W'(hw_q)) && !q_item.inv_gen;
	assign match  = (tbl_rdata == gen_q);
	assign bumped = {1'b0, tbl_rdata[GEN_WIDTH-2:0] + 1'b1};

	always_comb begin
		state_d   = state_q;
		fd_d      = fd_q;
		hw_d      = hw_q;
		scan_d    = scan_q;
		q_pop     = 1'b0;
		load_slot = 1'b0;
		emit      = 1'b0;
		e_status  = gha_pkg::ST_OK;
		e_index   = '0;
		e_gen     = '0;
		tbl_we    = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = '0;
		tbl_re    = 1'b0;
		tbl_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_item.op)
						gha_pkg::OP_CREATE: begin
							if (fd_q != '0) begin
								stk_re    = 1'b1;
								stk_raddr = IDX_W'(fd_q - 1'b1);
								fd_d      = fd_q - 1'b1;
								state_d   = S_STK;
							end else if (hw_q < CNT_W'(SLOT_COUNT)) begin
								tbl_we    = 1'b1;
								tbl_waddr = IDX_W'(hw_q);
								tbl_wdata = '0;
								hw_d      = hw_q + 1'b1;
								emit      = 1'b1;
								e_index   = gha_pkg::RIDX_W'(hw_q);
							end else begin
								emit     = 1'b1;
								e_status = gha_pkg::ST_FULL;
							end
						end
						gha_pkg::OP_DELETE, gha_pkg::OP_VALIDATE: begin
							if (pre_ok) begin
								tbl_re    = 1'b1;
								tbl_raddr = IDX_W'(q_item.idx);
								state_d   = S_CHK;
							end else begin
								emit     = 1'b1;
								e_status = gha_pkg::ST_STALE;
							end
						end
						default: begin
							scan_d  = CMP_W'(q_item.idx);
							state_d = S_SCAN;
						end
					endcase
				end
			end
			S_STK: begin
				tbl_re    = 1'b1;
				tbl_raddr = stk_rdata;
				load_slot = 1'b1;
				state_d   = S_REUSE;
			end
			S_REUSE: begin
				tbl_we    = 1'b1;
				tbl_waddr = slot_q;
				tbl_wdata = bumped;
				emit      = 1'b1;
				e_index   = gha_pkg::RIDX_W'(slot_q);
				e_gen     = gha_pkg::PGEN_W'(bumped);
				state_d   = S_IDLE;
			end
			S_CHK: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				if (match && (op_q == gha_pkg::OP_VALIDATE ||
						fd_q < CNT_W'(SLOT_COUNT))) begin
					e_index = gha_pkg::RIDX_W'(idx_q);
					e_gen   = gha_pkg::PGEN_W'(gen_q);
					if (op_q == gha_pkg::OP_DELETE) begin
						stk_we    = 1'b1;
						stk_waddr = IDX_W'(fd_q);
						stk_wdata = IDX_W'(idx_q);
						tbl_we    = 1'b1;
						tbl_waddr = IDX_W'(idx_q);
						tbl_wdata = {1'b1, tbl_rdata[GEN_WIDTH-2:0]};
						fd_d      = fd_q + 1'b1;
					end
				end else begin
					e_status = gha_pkg::ST_STALE;
				end
			end
			S_SCAN: begin
				if (scan_q < CMP_W'(hw_q)) begin
					tbl_re    = 1'b1;
					tbl_raddr = IDX_W'(scan_q);
					state_d   = S_SCAN_CHK;
				end else begin
					emit     = 1'b1;
					e_status = gha_pkg::ST_END;
					e_index  = gha_pkg::RIDX_W'(SLOT_COUNT);
					state_d  = S_IDLE;
				end
			end
			S_SCAN_CHK: begin
				if (!tbl_rdata[GEN_WIDTH-1]) begin
					emit    = 1'b1;
					e_index = gha_pkg::RIDX_W'(scan_q);
					e_gen   = gha_pkg::PGEN_W'(tbl_rdata);
					state_d = S_IDLE;
				end else begin
					scan_d  = scan_q + 1'b1;
					state_d = S_SCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fd_q    <= '0;
			hw_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fd_q    <= fd_d;
			hw_q    <= hw_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		if (q_pop) begin
			op_q  <= q_item.op;
			idx_q <= q_item.idx;
			gen_q <= GEN_WIDTH'(q_item.gen);
		end
		if (load_slot) begin
			slot_q <= stk_rdata;
		end
		if (emit) begin
			res_q.status <= e_status;
			res_q.index  <= e_index;
			res_q.gen    <= e_gen;
			res_q.live   <= gha_pkg::PCNT_W'(hw_d - fd_d);
			res_q.used   <= gha_pkg::PCNT_W'(hw_d);
		end
	end

	gha_ram #(
		.WIDTH (GEN_WIDTH),
		.DEPTH (SLOT_COUNT)
	) u_gen_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	gha_ram #(
		.WIDTH (IDX_W),
		.DEPTH (SLOT_COUNT)
	) u_free_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign done = done_q;
	assign res  = res_q;

endmodule

/* src/generational_handle_allocator_core.sv */
// top level of the generational handle allocator: front queue, back end and checks
//
// usage
// - command beat: drive mode, slot_index and generation with start high; the beat is
//   taken at a rising edge where start is high and busy is low
// - busy rises only while the two-entry command queue is full
// - result beat: done is high for exactly one cycle with status, result_index,
//   result_generation, live_count and used_slots; the receiver cannot hold it off
// - results come out in command order, one per command
// back end steps per command, from the queue to the result beat
// - fresh create, full, or a handle rejected on range or free flag: straight from idle
// - delete or validate that reads the table: table read, then check
// - create that reuses a freed slot: free stack read, then table read, then table write
// - scan: a table read and a check for each slot read, to a live slot or to the end
// - queued commands add the back end time of the ones ahead of them
// reset
// - arst_n clears the queue, slot counts and strobe; the generation table and free
//   stack are not cleared, since no entry is read before it is written
module generational_handle_allocator_core #(
	parameter int SLOT_COUNT = 256,
	parameter int GEN_WIDTH  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [gha_pkg::MODE_W-1:0]   mode,
	input  logic [gha_pkg::SLOT_W-1:0]   slot_index,
	input  logic [gha_pkg::PGEN_W-1:0]   generation,
	output logic                         done,
	output logic [gha_pkg::STATUS_W-1:0] status,
	output logic [gha_pkg::RIDX_W-1:0]   result_index,
	output logic [gha_pkg::PGEN_W-1:0]   result_generation,
	output logic [gha_pkg::PCNT_W-1:0]   live_count,
	output logic [gha_pkg::PCNT_W-1:0]   used_slots
);

	// classified command beats waiting for the back end
	logic          q_valid;
	gha_pkg::cmd_t q_item;
	logic          q_pop;
	gha_pkg::res_t res;

	// front: handshake, mode decode, free-flag check of the handle word, queue
	gha_front #(
		.GEN_WIDTH (GEN_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.slot_index (slot_index),
		.generation (generation),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// back: table and stack memories, counts, scan walker, result register
	gha_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_WIDTH  (GEN_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.done    (done),
		.res     (res)
	);

	// result beat fan-out
	assign status            = res.status;
	assign result_index      = res.index;
	assign result_generation = res.gen;
	assign live_count        = res.live;
	assign used_slots        = res.used;

	// back end never pops an empty queue
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty command queue");

	// full means no freed slot, so every used slot is live
	a_full_all_live: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == gha_pkg::ST_FULL) |-> (live_count == used_slots))
		else $error("full reported with freed slots pending");

	// rejected beats carry zero index and generation
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == gha_pkg::ST_FULL || status == gha_pkg::ST_STALE)) |->
		(result_index == '0 && result_generation == '0))
		else $error("rejected result carries payload");

	// end of scan points past the last slot
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == gha_pkg::ST_END) |->
		(result_index == gha_pkg::RIDX_W'(SLOT_COUNT) && result_generation == '0))
		else $error("scan end with wrong index");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the generational handle allocator core
module tb;

	localparam int SLOTS = 256;
	localparam logic [gha_pkg::PGEN_W-1:0] FREE_BIT   = 32'h8000_0000;
	localparam logic [gha_pkg::PGEN_W-1:0] COUNT_MASK = 32'h7fff_ffff;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         start      = 1'b0;
	logic [gha_pkg::MODE_W-1:0]   mode       = gha_pkg::OP_CREATE;
	logic [gha_pkg::SLOT_W-1:0]   slot_index = '0;
	logic [gha_pkg::PGEN_W-1:0]   generation = '0;
	logic                         busy;
	logic                         done;
	logic [gha_pkg::STATUS_W-1:0] status;
	logic [gha_pkg::RIDX_W-1:0]   result_index;
	logic [gha_pkg::PGEN_W-1:0]   result_generation;
	logic [gha_pkg::PCNT_W-1:0]   live_count;
	logic [gha_pkg::PCNT_W-1:0]   used_slots;

	generational_handle_allocator_core #(
		.SLOT_COUNT(SLOTS),
		.GEN_WIDTH (gha_pkg::PGEN_W)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.mode             (mode),
		.slot_index       (slot_index),
		.generation       (generation),
		.done             (done),
		.status           (status),
		.result_index     (result_index),
		.result_generation(result_generation),
		.live_count       (live_count),
		.used_slots       (used_slots)
	);

	always #6 clk = ~clk;

	// mirror of the allocator state
	logic [gha_pkg::PGEN_W-1:0] slot_gen [SLOTS];
	logic [gha_pkg::SLOT_W-1:0] free_slots [SLOTS];
	int                         free_depth = 0;
	int                         high_water = 0;

	gha_pkg::res_t pending_results [$];
	int            errors = 0;
	int            op_seen [4] = '{default: 0};
	int            status_seen [4] = '{default: 0};

	function automatic bit handle_live(int idx, logic [gha_pkg::PGEN_W-1:0] gen);
		return idx < high_water && !gen[gha_pkg::PGEN_W-1] && gen == slot_gen[idx];
	endfunction

	// expected result beat of one command, updating the mirror
	function automatic gha_pkg::res_t predict_beat(gha_pkg::op_t op,
			logic [gha_pkg::SLOT_W-1:0] idx, logic [gha_pkg::PGEN_W-1:0] gen);
		gha_pkg::res_t r;
		int   i;
		logic [gha_pkg::SLOT_W-1:0] s;
		r.status = gha_pkg::ST_OK;
		r.index  = '0;
		r.gen    = '0;
		case (op)
			gha_pkg::OP_CREATE: begin
				if (free_depth > 0) begin
					// most recently freed slot first, counter wraps below the flag
					free_depth--;
					s = free_slots[free_depth];
					slot_gen[s] = ((slot_gen[s] & COUNT_MASK) + 32'd1) & COUNT_MASK;
					r.index = gha_pkg::RIDX_W'(s);
					r.gen   = slot_gen[s];
				end else if (high_water < SLOTS) begin
					slot_gen[high_water] = '0;
					r.index = gha_pkg::RIDX_W'(high_water);
					high_water++;
				end else begin
					r.status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::OP_DELETE: begin
				if (handle_live(idx, gen) && free_depth < SLOTS) begin
					free_slots[free_depth] = idx;
					free_depth++;
					slot_gen[idx] = slot_gen[idx] | FREE_BIT;
					r.index = gha_pkg::RIDX_W'(idx);
					r.gen   = gen;
				end else begin
					r.status = gha_pkg::ST_STALE;
				end
			end
			gha_pkg::OP_VALIDATE: begin
				if (handle_live(idx, gen)) begin
					r.index = gha_pkg::RIDX_W'(idx);
					r.gen   = gen;
				end else begin
					r.status = gha_pkg::ST_STALE;
				end
			end
			default: begin
				i = idx;
				while (i < high_water && slot_gen[i][gha_pkg::PGEN_W-1])
					i++;
				if (i < high_water) begin
					r.index = gha_pkg::RIDX_W'(i);
					r.gen   = slot_gen[i];
				end else begin
					r.status = gha_pkg::ST_END;
					r.index  = gha_pkg::RIDX_W'(SLOTS);
				end
			end
		endcase
		r.live = gha_pkg::PCNT_W'(high_water - free_depth);
		r.used = gha_pkg::PCNT_W'(high_water);
		return r;
	endfunction

	task automatic flag_error(string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// result beats are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		gha_pkg::res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result beat with nothing pending, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					flag_error($sformatf("status %0d, want %0d", status, want.status));
				if (result_index !== want.index)
					flag_error($sformatf("result_index %0d, want %0d", result_index, want.index));
				if (result_generation !== want.gen)
					flag_error($sformatf("result_generation %h, want %h",
						result_generation, want.gen));
				if (live_count !== want.live)
					flag_error($sformatf("live_count %0d, want %0d", live_count, want.live));
				if (used_slots !== want.used)
					flag_error($sformatf("used_slots %0d, want %0d", used_slots, want.used));
				status_seen[want.status]++;
			end
		end
	end

	// one command beat; start stays high so the next beat can follow at once
	task automatic send_beat(gha_pkg::op_t op, logic [gha_pkg::SLOT_W-1:0] idx,
			logic [gha_pkg::PGEN_W-1:0] gen);
		bit taken;
		start      <= 1'b1;
		mode       <= op;
		slot_index <= idx;
		generation <= gen;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = (busy === 1'b0);
			@(posedge clk);
		end
		pending_results.push_back(predict_beat(op, idx, gen));
		op_seen[op]++;
	endtask

	task automatic idle_gap(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic pause_until_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// mostly live handles, some with one bit off, some pure noise
	task automatic pick_handle(output logic [gha_pkg::SLOT_W-1:0] idx,
			output logic [gha_pkg::PGEN_W-1:0] gen);
		int r;
		int k;
		r = $urandom_range(99);
		if (high_water == 0 || r >= 85) begin
			idx = gha_pkg::SLOT_W'($urandom);
			gen = $urandom;
			if ($urandom_range(1))
				gen[gha_pkg::PGEN_W-1] = 1'b0;
		end else if (r >= 70) begin
			idx = gha_pkg::SLOT_W'($urandom_range(high_water - 1));
			gen = slot_gen[idx] ^ (32'h1 << $urandom_range(gha_pkg::PGEN_W - 1));
		end else begin
			k = 0;
			idx = gha_pkg::SLOT_W'($urandom_range(high_water - 1));
			while (slot_gen[idx][gha_pkg::PGEN_W-1] && k < 8) begin
				idx = gha_pkg::SLOT_W'($urandom_range(high_water - 1));
				k++;
			end
			gen = slot_gen[idx];
		end
	endtask

	task automatic random_traffic(int count, int create_pct, int idle_pct);
		gha_pkg::op_t               op;
		logic [gha_pkg::SLOT_W-1:0] idx;
		logic [gha_pkg::PGEN_W-1:0] gen;
		int                         r;
		for (int n = 0; n < count; n++) begin
			if (idle_pct > 0 && $urandom_range(59) == 0)
				pause_until_drained();
			else if ($urandom_range(99) < idle_pct)
				idle_gap($urandom_range(1, 5));
			pick_handle(idx, gen);
			r = $urandom_range(99);
			if ($urandom_range(99) < create_pct) begin
				op  = gha_pkg::OP_CREATE;
				idx = gha_pkg::SLOT_W'($urandom);
				gen = $urandom;
			end else if (r < 50) begin
				op = gha_pkg::OP_DELETE;
			end else if (r < 85) begin
				op = gha_pkg::OP_VALIDATE;
			end else begin
				op = gha_pkg::OP_SCAN;
				if (r < 93 && high_water > 0)
					idx = gha_pkg::SLOT_W'($urandom_range(high_water - 1));
			end
			send_beat(op, idx, gen);
		end
		pause_until_drained();
	endtask

	task automatic test_directed();
		send_beat(gha_pkg::OP_SCAN,     8'd0,   32'h0000_0000);  // scan of an empty map
		send_beat(gha_pkg::OP_VALIDATE, 8'd0,   32'h0000_0000);  // nothing allocated yet
		send_beat(gha_pkg::OP_DELETE,   8'd0,   32'h0000_0000);
		send_beat(gha_pkg::OP_CREATE,   8'd0,   32'h0000_0000);  // fresh slots 0, 1, 2
		send_beat(gha_pkg::OP_CREATE,   8'd255, 32'hffff_ffff);
		send_beat(gha_pkg::OP_CREATE,   8'd0,   32'h0000_0000);
		send_beat(gha_pkg::OP_VALIDATE, 8'd0,   32'h0000_0000);
		send_beat(gha_pkg::OP_VALIDATE, 8'd0,   32'h8000_0000);  // free flag in the handle
		send_beat(gha_pkg::OP_VALIDATE, 8'd1,   32'h0000_0001);  // wrong generation
		send_beat(gha_pkg::OP_VALIDATE, 8'd255, 32'h0000_0000);  // beyond used slots
		send_beat(gha_pkg::OP_DELETE,   8'd1,   32'h0000_0000);
		send_beat(gha_pkg::OP_VALIDATE, 8'd1,   32'h0000_0000);  // freed handle is stale
		send_beat(gha_pkg::OP_DELETE,   8'd1,   32'h0000_0000);  // double free
		send_beat(gha_pkg::OP_DELETE,   8'd1,   32'h8000_0000);  // freed word itself
		send_beat(gha_pkg::OP_SCAN,     8'd1,   32'h0000_0000);  // skips the free slot
		send_beat(gha_pkg::OP_SCAN,     8'd3,   32'h0000_0000);
		send_beat(gha_pkg::OP_DELETE,   8'd2,   32'h0000_0000);
		send_beat(gha_pkg::OP_SCAN,     8'd1,   32'h0000_0000);  // only free slots left
		send_beat(gha_pkg::OP_CREATE,   8'd0,   32'h0000_0000);  // reuse, last freed first
		send_beat(gha_pkg::OP_CREATE,   8'd0,   32'h0000_0000);
		send_beat(gha_pkg::OP_CREATE,   8'd0,   32'h0000_0000);  // stack empty again, fresh
		send_beat(gha_pkg::OP_VALIDATE, 8'd2,   32'h0000_0001);
		send_beat(gha_pkg::OP_DELETE,   8'd0,   32'hffff_ffff);
		send_beat(gha_pkg::OP_SCAN,     8'd255, 32'hffff_ffff);
		pause_until_drained();
	endtask

	// create-heavy until the map is full and stays full for a while
	task automatic test_fill_to_full();
		random_traffic(650, 70, 8);
	endtask

	// delete-heavy: deep free stack, long scans, reuse of old slots
	task automatic test_drain_and_reuse();
		random_traffic(600, 15, 51);
	endtask

	// balanced mix with beats back to back
	task automatic test_mixed_back_to_back();
		random_traffic(600, 45, 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_to_full();
		test_drain_and_reuse();
		test_mixed_back_to_back();
		repeat (10) @(posedge clk);
		$display("tb: beats sent: create %0d, delete %0d, validate %0d, scan %0d",
			op_seen[gha_pkg::OP_CREATE], op_seen[gha_pkg::OP_DELETE],
			op_seen[gha_pkg::OP_VALIDATE], op_seen[gha_pkg::OP_SCAN]);
		$display("tb: results ok %0d, full %0d, stale %0d, scan end %0d; %0d mismatches",
			status_seen[gha_pkg::ST_OK], status_seen[gha_pkg::ST_FULL],
			status_seen[gha_pkg::ST_STALE], status_seen[gha_pkg::ST_END], errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("tb: timeout");
		$display("tb: failure");
		$finish;
	end

endmodule
